FILE: hw/rtl/spq_pkg.sv
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OccW = 5;
  localparam int unsigned SevW = 8;
  localparam int unsigned LocW = 16;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [OccW-1:0] occ_t;
  typedef logic [SevW-1:0] sev_t;
  typedef logic [LocW-1:0] loc_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    sev_t severity;
    loc_t location;
  } entry_t;

  // One write port and one read port of the entry store.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/spq_ram.sv
// Entry store of the queue: one write port, one registered read port.
module spq_ram (
  input  logic              clk_i,
  input  spq_pkg::mem_req_t req_i,
  output spq_pkg::entry_t   rdata_o
);
  import spq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue top level: sequencer, shared compare and address unit, entry store.
// An insert walks back from the tail, moving each stored entry that must move back one slot,
// then writes the new word; a pop keeps the front entry and moves every remaining entry
// forward; a full insert or an empty pop answers with its status and no walk. Busy drops
// as the word shows, so one word per pass.
// Reset clears the count and the sequencer; the entry store itself is not cleared.
module sorted_priority_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  spq_pkg::sev_t        severity_i,
  input  spq_pkg::loc_t        location_i,
  output logic                 valid_o,
  output spq_pkg::status_e     status_o,
  output spq_pkg::sev_t        out_severity_o,
  output spq_pkg::loc_t        out_location_o,
  output spq_pkg::occ_t        occupancy_o
);
  import spq_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_INS_RD    = 3'd1;
  localparam logic [2:0] ST_INS_CMP   = 3'd2;
  localparam logic [2:0] ST_POP_FRONT = 3'd3;
  localparam logic [2:0] ST_POP_RD    = 3'd4;
  localparam logic [2:0] ST_POP_WR    = 3'd5;

  logic [2:0] state_q, state_d;
  cnt_t       idx_q, idx_d;
  cnt_t       cnt_q, cnt_d;
  sev_t       sev_q, sev_d;
  loc_t       loc_q, loc_d;
  logic       valid_q, valid_d;
  status_e    status_q, status_d;
  sev_t       osev_q, osev_d;
  loc_t       oloc_q, oloc_d;
  occ_t       occ_q, occ_d;

  mem_req_t   req;
  entry_t     rdata;
  entry_t     new_entry;

  // The shared unit: one cursor decrement, one cursor increment and one severity compare.
  cnt_t       idx_m1;
  cnt_t       idx_p1;
  logic       stored_greater;

  assign idx_m1         = idx_q - cnt_t'(1);
  assign idx_p1         = idx_q + cnt_t'(1);
  assign stored_greater = rdata.severity > sev_q;
  assign new_entry      = '{severity: sev_q, location: loc_q};

  spq_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    sev_d    = sev_q;
    loc_d    = loc_q;
    valid_d  = 1'b0;
    status_d = status_q;
    osev_d   = osev_q;
    oloc_d   = oloc_q;
    occ_d    = occ_q;
    req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        // The store reads the front entry here, so a pop finds it ready next cycle.
        if (start) begin
          sev_d  = severity_i;
          loc_d  = location_i;
          osev_d = '0;
          oloc_d = '0;
          idx_d  = cnt_q;
          if (mode_i == MODE_INSERT) begin
            if (cnt_q == cnt_t'(QUEUE_DEPTH)) begin
              valid_d  = 1'b1;
              status_d = STATUS_FULL;
              occ_d    = occ_t'(cnt_q);
            end else begin
              state_d = ST_INS_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              valid_d  = 1'b1;
              status_d = STATUS_EMPTY;
              occ_d    = occ_t'(cnt_q);
            end else begin
              state_d = ST_POP_FRONT;
            end
          end
        end
      end

      // Walk back from the tail: fetch the entry just ahead of the open slot, or at the front store the new word.
      ST_INS_RD: begin
        if (idx_q == '0) begin
          req.we    = 1'b1;
          req.waddr = idx_q[IdxW-1:0];
          req.wdata = new_entry;
          cnt_d     = cnt_q + cnt_t'(1);
          valid_d   = 1'b1;
          status_d  = STATUS_OK;
          occ_d     = occ_t'(cnt_q + cnt_t'(1));
          state_d   = ST_IDLE;
        end else begin
          req.raddr = idx_m1[IdxW-1:0];
          state_d   = ST_INS_CMP;
        end
      end

      // A strictly greater entry moves back one slot; otherwise the new word lands here.
      ST_INS_CMP: begin
        req.we    = 1'b1;
        req.waddr = idx_q[IdxW-1:0];
        if (stored_greater) begin
          req.wdata = rdata;
          idx_d     = idx_m1;
          state_d   = ST_INS_RD;
        end else begin
          req.wdata = new_entry;
          cnt_d     = cnt_q + cnt_t'(1);
          valid_d   = 1'b1;
          status_d  = STATUS_OK;
          occ_d     = occ_t'(cnt_q + cnt_t'(1));
          state_d   = ST_IDLE;
        end
      end

      // The front entry is on the read port: keep it as the result.
      ST_POP_FRONT: begin
        osev_d  = rdata.severity;
        oloc_d  = rdata.location;
        idx_d   = cnt_t'(1);
        state_d = ST_POP_RD;
      end

      // Move every remaining entry forward by one slot, then finish the pop.
      ST_POP_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d    = cnt_q - cnt_t'(1);
          valid_d  = 1'b1;
          status_d = STATUS_OK;
          occ_d    = occ_t'(cnt_q - cnt_t'(1));
          state_d  = ST_IDLE;
        end else begin
          req.raddr = idx_q[IdxW-1:0];
          state_d   = ST_POP_WR;
        end
      end

      ST_POP_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_m1[IdxW-1:0];
        req.wdata = rdata;
        idx_d     = idx_p1;
        state_d   = ST_POP_RD;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    sev_q    <= sev_d;
    loc_q    <= loc_d;
    status_q <= status_d;
    osev_q   <= osev_d;
    oloc_q   <= oloc_d;
    occ_q    <= occ_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign out_severity_o = osev_q;
  assign out_location_o = oloc_q;
  assign occupancy_o    = occ_q;

endmodule
